// ===== src/lprf_pkg.sv =====
// Package for the length-prefixed record ring FIFO: operation and status codes,
// controller states and fixed field widths. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lprf_pkg;

  localparam int unsigned LEN_W   = 10;  // record length field
  localparam int unsigned DATA_W  = 32;  // data word field on the ports
  localparam int unsigned COUNT_W = 32;  // record counters
  localparam int unsigned FREE_W  = 10;  // free-slot report
  localparam logic [FREE_W-1:0] FREE_MAX = '1;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_WORD_TAKEN = 3'd0,
    ST_COMMITTED  = 3'd1,
    ST_NO_ROOM    = 3'd2,
    ST_BAD_LEN    = 3'd3,
    ST_WORD_READ  = 3'd4,
    ST_EMPTY      = 3'd5,
    ST_CLEARED    = 3'd6,
    ST_DISCARDED  = 3'd7
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WR_DATA,
    S_RD_LEN,
    S_RD_DATA,
    S_RESP
  } state_e;

endpackage

`default_nettype wire

// ===== src/length_prefixed_record_ring_fifo.sv =====
// Top level of the length-prefixed record ring FIFO: controller, pointers,
// counters and output register. Uses lprf_pkg and lprf_ram.
`timescale 1ns / 1ps
`default_nettype none

// - Input channel s_axis_*: one word per handshake. tuser carries the
//   operation (write one record word, read one word, clear). A record's first
//   write word also carries its length; the header is stored ahead of the data.
// - A record is admitted only when length > 0 and committed fill + length + 1 < DEPTH;
//   otherwise it is refused (no room / bad length) and its remaining words
//   are swallowed with a discarded status. Readers see a record only once its
//   last word has been written.
// - Output channel m_axis_*: exactly one result word per input word, in order.
//   tuser is the status, tlast marks the last data word of a record on a read.
// - Throughput: one word at a time; a new word is taken only once the result of
//   the last one has gone to the output register. A word that starts a record
//   also passes S_WR_DATA (header and data are two writes to the single write
//   port of the ring), a read passes S_RD_DATA (registered RAM read), and the
//   first read of a record passes S_RD_LEN before it (header fetch before the data).
// - Latency: the result is registered, loaded from S_RESP after the states above.
// - Stall: the result sits in the output register; a new word is taken while
//   it waits, but its own result is held back until the register is free.
// - Reset: pointers, counters and record progress go to zero, the output is
//   empty. Ring contents are not cleared; nothing unwritten is ever read.
//   Clear does the same to the pointers in one word.
module length_prefixed_record_ring_fifo #(
  parameter int unsigned DEPTH     = 1024,
  parameter int unsigned WORD_BITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input words
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,  // [31:0] data_word, [41:32] record_len, pad
  input  wire logic [1:0]  s_axis_tuser,  // [1:0] op
  // result words
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [79:0] m_axis_tdata,  // [31:0] data_out, [63:32] record_count,
                                          // [73:64] free_words, pad
  output logic             m_axis_tlast,  // record_last
  output logic      [2:0]  m_axis_tuser   // [2:0] status
);

  localparam int unsigned LEN_W   = lprf_pkg::LEN_W;
  localparam int unsigned DATA_W  = lprf_pkg::DATA_W;
  localparam int unsigned COUNT_W = lprf_pkg::COUNT_W;
  localparam int unsigned FREE_W  = lprf_pkg::FREE_W;

  localparam int unsigned ADDR_W  = $clog2(DEPTH);
  localparam int unsigned PTR_W   = $clog2(2 * DEPTH);    // pointers run mod 2*DEPTH
  localparam int unsigned SLOT_W  = (WORD_BITS > LEN_W) ? WORD_BITS : LEN_W;
  localparam int unsigned IO_W    = (WORD_BITS < DATA_W) ? WORD_BITS : DATA_W;
  localparam int unsigned CMP_W   = ((PTR_W > LEN_W) ? PTR_W : LEN_W) + 2;
  localparam logic [PTR_W:0]   PTR_MOD = (PTR_W + 1)'(2 * DEPTH);
  localparam logic [PTR_W-1:0] DEPTH_P = PTR_W'(DEPTH);
  localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);
  localparam int unsigned FREE_MAX_C = (1 << FREE_W) - 1;

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
    logic [PTR_W:0] s;
    s = {1'b0, p} + 1'b1;
    return (s == PTR_MOD) ? '0 : s[PTR_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] slot_of(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] t;
    t = (p >= DEPTH_P) ? (p - DEPTH_P) : p;
    return t[ADDR_W-1:0];
  endfunction

  // ---------------------------------------------------------------- state
  lprf_pkg::state_e state_q, state_d;

  logic [PTR_W-1:0]   cin_q, cin_d;     // committed write pointer
  logic [PTR_W-1:0]   fout_q, fout_d;   // freed read pointer
  logic [PTR_W-1:0]   wc_q, wc_d;       // write cursor
  logic [LEN_W-1:0]   wleft_q, wleft_d;
  logic               wdisc_q, wdisc_d;
  logic [PTR_W-1:0]   rc_q, rc_d;       // read cursor
  logic [LEN_W-1:0]   rleft_q, rleft_d;
  logic [COUNT_W-1:0] rin_q, rin_d;
  logic [COUNT_W-1:0] rout_q, rout_d;

  // held item data and pending result
  logic [IO_W-1:0]    data_q, data_d;
  logic [2:0]         res_status_q, res_status_d;
  logic [DATA_W-1:0]  res_data_q, res_data_d;
  logic               res_last_q, res_last_d;
  logic [COUNT_W-1:0] res_count_q, res_count_d;

  logic               out_valid_q;
  logic               load_out;

  // ---------------------------------------------------------------- ring
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [SLOT_W-1:0] mem_wdata, mem_rdata;

  lprf_ram #(
    .DEPTH (DEPTH),
    .WIDTH (SLOT_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // ---------------------------------------------------------------- fill
  logic [PTR_W:0]     fill_w;
  logic [CMP_W-1:0]   fill_c, free_c;
  logic [FREE_W-1:0]  free_words;

  always_comb begin
    if (cin_q >= fout_q) begin
      fill_w = {1'b0, cin_q} - {1'b0, fout_q};
    end else begin
      fill_w = {1'b0, cin_q} + (PTR_MOD - {1'b0, fout_q});
    end
    fill_c = CMP_W'(fill_w);
    free_c = (fill_c >= DEPTH_C) ? '0 : (DEPTH_C - fill_c);
    free_words = (free_c > CMP_W'(FREE_MAX_C)) ? lprf_pkg::FREE_MAX : free_c[FREE_W-1:0];
  end

  // ---------------------------------------------------------------- input view
  logic [IO_W-1:0]  in_data;
  logic [LEN_W-1:0] in_len;
  lprf_pkg::op_e    in_op;

  assign in_data = s_axis_tdata[IO_W-1:0];
  assign in_len  = s_axis_tdata[DATA_W +: LEN_W];
  assign in_op   = lprf_pkg::op_e'(s_axis_tuser);

  assign s_axis_tready = (state_q == lprf_pkg::S_IDLE);

  // ---------------------------------------------------------------- control
  logic              do_data_wr;
  logic [IO_W-1:0]   wr_src;
  logic [SLOT_W-1:0] wr_word;
  logic [LEN_W-1:0]  wleft_dec;
  logic [DATA_W-1:0] rd_word;

  always_comb begin
    wr_word = '0;
    wr_word[IO_W-1:0] = wr_src;
    rd_word = '0;
    rd_word[IO_W-1:0] = mem_rdata[IO_W-1:0];
  end

  assign wr_src    = (state_q == lprf_pkg::S_WR_DATA) ? data_q : in_data;
  assign wleft_dec = wleft_q - 1'b1;

  always_comb begin
    state_d      = state_q;
    cin_d        = cin_q;
    fout_d       = fout_q;
    wc_d         = wc_q;
    wleft_d      = wleft_q;
    wdisc_d      = wdisc_q;
    rc_d         = rc_q;
    rleft_d      = rleft_q;
    rin_d        = rin_q;
    rout_d       = rout_q;
    data_d       = data_q;
    res_status_d = res_status_q;
    res_data_d   = res_data_q;
    res_last_d   = res_last_q;
    res_count_d  = res_count_q;
    mem_we       = 1'b0;
    mem_waddr    = slot_of(wc_q);
    mem_wdata    = wr_word;
    mem_re       = 1'b0;
    mem_raddr    = slot_of(rc_q);
    do_data_wr   = 1'b0;
    load_out     = 1'b0;

    unique case (state_q)
      lprf_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          data_d       = in_data;
          res_data_d   = '0;
          res_last_d   = 1'b0;
          res_count_d  = '0;
          res_status_d = lprf_pkg::ST_DISCARDED;
          state_d      = lprf_pkg::S_RESP;
          unique case (in_op)
            lprf_pkg::OP_WRITE: begin
              if (wdisc_q) begin
                wleft_d = wleft_dec;
                if (wleft_dec == '0) begin
                  wdisc_d = 1'b0;
                end
              end else if (wleft_q != '0) begin
                do_data_wr = 1'b1;                 // word inside a record
              end else if (in_len == '0) begin
                res_status_d = lprf_pkg::ST_BAD_LEN;
              end else if (CMP_W'(in_len) > DEPTH_C) begin
                res_status_d = lprf_pkg::ST_BAD_LEN;
                if (in_len > LEN_W'(1)) begin
                  wdisc_d = 1'b1;
                  wleft_d = in_len - 1'b1;
                end
              end else if (fill_c + CMP_W'(in_len) + 1'b1 >= DEPTH_C) begin
                res_status_d = lprf_pkg::ST_NO_ROOM;
                if (in_len > LEN_W'(1)) begin
                  wdisc_d = 1'b1;
                  wleft_d = in_len - 1'b1;
                end
              end else begin
                // header now, data word next cycle
                mem_we    = 1'b1;
                mem_waddr = slot_of(cin_q);
                mem_wdata = SLOT_W'(in_len);
                wc_d      = advance(cin_q);
                wleft_d   = in_len;
                state_d   = lprf_pkg::S_WR_DATA;
              end
            end
            lprf_pkg::OP_READ: begin
              if (rleft_q != '0) begin
                mem_re    = 1'b1;
                mem_raddr = slot_of(rc_q);
                state_d   = lprf_pkg::S_RD_DATA;
              end else if (fout_q == cin_q) begin
                res_status_d = lprf_pkg::ST_EMPTY;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = slot_of(fout_q);
                state_d   = lprf_pkg::S_RD_LEN;
              end
            end
            lprf_pkg::OP_CLEAR: begin
              cin_d        = '0;
              fout_d       = '0;
              wc_d         = '0;
              wleft_d      = '0;
              wdisc_d      = 1'b0;
              rc_d         = '0;
              rleft_d      = '0;
              rin_d        = '0;
              rout_d       = '0;
              res_status_d = lprf_pkg::ST_CLEARED;
            end
            default: begin
              // spare op code: answered with a discarded status, no other effect
            end
          endcase
        end
      end
      lprf_pkg::S_WR_DATA: begin
        do_data_wr = 1'b1;
        state_d    = lprf_pkg::S_RESP;
      end
      lprf_pkg::S_RD_LEN: begin
        rleft_d   = mem_rdata[LEN_W-1:0];
        rc_d      = advance(fout_q);
        mem_re    = 1'b1;
        mem_raddr = slot_of(advance(fout_q));
        state_d   = lprf_pkg::S_RD_DATA;
      end
      lprf_pkg::S_RD_DATA: begin
        res_data_d   = rd_word;
        res_status_d = lprf_pkg::ST_WORD_READ;
        rc_d         = advance(rc_q);
        rleft_d      = rleft_q - 1'b1;
        if (rleft_q == LEN_W'(1)) begin
          fout_d      = advance(rc_q);
          rout_d      = rout_q + 1'b1;
          res_last_d  = 1'b1;
          res_count_d = rout_q + 1'b1;
        end
        state_d = lprf_pkg::S_RESP;
      end
      lprf_pkg::S_RESP: begin
        if (!out_valid_q || m_axis_tready) begin
          load_out = 1'b1;
          state_d  = lprf_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = lprf_pkg::S_IDLE;
      end
    endcase

    // data word of an admitted record; commit on its last word
    if (do_data_wr) begin
      mem_we       = 1'b1;
      mem_waddr    = slot_of(wc_q);
      mem_wdata    = wr_word;
      wc_d         = advance(wc_q);
      wleft_d      = wleft_dec;
      res_status_d = lprf_pkg::ST_WORD_TAKEN;
      if (wleft_dec == '0) begin
        cin_d        = advance(wc_q);
        rin_d        = rin_q + 1'b1;
        res_status_d = lprf_pkg::ST_COMMITTED;
        res_count_d  = rin_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lprf_pkg::S_IDLE;
      cin_q   <= '0;
      fout_q  <= '0;
      wc_q    <= '0;
      wleft_q <= '0;
      wdisc_q <= 1'b0;
      rc_q    <= '0;
      rleft_q <= '0;
      rin_q   <= '0;
      rout_q  <= '0;
    end else begin
      state_q <= state_d;
      cin_q   <= cin_d;
      fout_q  <= fout_d;
      wc_q    <= wc_d;
      wleft_q <= wleft_d;
      wdisc_q <= wdisc_d;
      rc_q    <= rc_d;
      rleft_q <= rleft_d;
      rin_q   <= rin_d;
      rout_q  <= rout_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q       <= data_d;
    res_status_q <= res_status_d;
    res_data_q   <= res_data_d;
    res_last_q   <= res_last_d;
    res_count_q  <= res_count_d;
  end

  // ---------------------------------------------------------------- output
  // free_words is taken from the pointers as they stand after the word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      m_axis_tdata <= {6'b0, free_words, res_count_q, res_data_q};
      m_axis_tuser <= res_status_q;
      m_axis_tlast <= res_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;

endmodule

`default_nettype wire

// ===== src/lprf_ram.sv =====
// Simple dual-port synchronous RAM for the record ring: one write port,
// one read port with registered data. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lprf_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire
